### rtl/iepq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iepq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int KEY_LIMIT_DEF   = 767;

    // key map is stored as rows of 16 bits
    localparam int KMAP_ROW_W  = 16;
    localparam int KMAP_ROW_SH = 4;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic [4:0] TYPE_SYN = 5'd0;
    localparam logic [4:0] TYPE_KEY = 5'd1;
    localparam logic [4:0] TYPE_REL = 5'd2;

    localparam logic [9:0] BTN_BASE   = 10'h110;
    localparam logic [9:0] AXIS_X     = 10'd0;
    localparam logic [9:0] AXIS_Y     = 10'd1;
    localparam logic [9:0] AXIS_WHEEL = 10'd8;

    // event slots of one push, in queue order
    localparam logic [2:0] SLOT_BTN_L = 3'd0;
    localparam logic [2:0] SLOT_BTN_R = 3'd1;
    localparam logic [2:0] SLOT_BTN_M = 3'd2;
    localparam logic [2:0] SLOT_REL_X = 3'd3;
    localparam logic [2:0] SLOT_REL_Y = 3'd4;
    localparam logic [2:0] SLOT_REL_W = 3'd5;
    localparam logic [2:0] SLOT_KEY   = 3'd6;
    localparam logic [2:0] SLOT_SYN   = 3'd7;
    localparam int         NUM_SLOTS  = 8;

    typedef struct packed {
        logic [4:0]  ev_type;
        logic [9:0]  ev_code;
        logic [15:0] ev_value;
    } event_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  key_code;
        logic        key_down;
        logic [2:0]  buttons;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
    } record_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_en;
        logic [3:0]           count;
        logic                 ignore;
        logic                 kmap_upd;
    } gen_t;

endpackage

`default_nettype wire

### rtl/iepq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module iepq_ram #(
    parameter int WIDTH = $bits(iepq_pkg::event_t),
    parameter int DEPTH = iepq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/iepq_evgen.sv
`timescale 1ns / 1ps
`default_nettype none

module iepq_evgen #(
    parameter int KEY_LIMIT = iepq_pkg::KEY_LIMIT_DEF
) (
    input  wire iepq_pkg::record_t rec,
    input  wire logic [2:0]        held,
    input  wire logic [2:0]        slot,
    output      iepq_pkg::gen_t    gen,
    output      iepq_pkg::event_t  ev
);

    localparam logic [10:0] KEY_LIM      = 11'(KEY_LIMIT);
    localparam logic        KMAP_HAS_BTN = (KEY_LIMIT >= int'(iepq_pkg::BTN_BASE));

    logic [2:0] changed;

    always_comb
    begin
        changed = rec.buttons ^ held;
        gen     = '0;
        if (rec.kind)
        begin
            gen.slot_en[2:0]                 = changed;
            gen.slot_en[iepq_pkg::SLOT_REL_X] = (rec.dx != 16'd0);
            gen.slot_en[iepq_pkg::SLOT_REL_Y] = (rec.dy != 16'd0);
            gen.slot_en[iepq_pkg::SLOT_REL_W] = (rec.dz != 16'd0);
            gen.slot_en[iepq_pkg::SLOT_SYN]   = 1'b1;
            gen.kmap_upd                      = KMAP_HAS_BTN;
        end
        else
        begin
            gen.ignore = (rec.key_code == 10'd0) || ({1'b0, rec.key_code} >= KEY_LIM);
            gen.slot_en[iepq_pkg::SLOT_KEY] = 1'b1;
            gen.slot_en[iepq_pkg::SLOT_SYN] = 1'b1;
            gen.kmap_upd                    = !gen.ignore;
        end
        for (int i = 0; i < iepq_pkg::NUM_SLOTS; i++)
        begin
            gen.count = gen.count + 4'(gen.slot_en[i]);
        end
    end

    always_comb
    begin
        ev = '0;
        case (slot)
            iepq_pkg::SLOT_BTN_L, iepq_pkg::SLOT_BTN_R, iepq_pkg::SLOT_BTN_M:
            begin
                ev.ev_type  = iepq_pkg::TYPE_KEY;
                ev.ev_code  = iepq_pkg::BTN_BASE + 10'(slot[1:0]);
                ev.ev_value = 16'(rec.buttons[slot[1:0]]);
            end
            iepq_pkg::SLOT_REL_X:
            begin
                ev.ev_type  = iepq_pkg::TYPE_REL;
                ev.ev_code  = iepq_pkg::AXIS_X;
                ev.ev_value = rec.dx;
            end
            iepq_pkg::SLOT_REL_Y:
            begin
                ev.ev_type  = iepq_pkg::TYPE_REL;
                ev.ev_code  = iepq_pkg::AXIS_Y;
                ev.ev_value = rec.dy;
            end
            iepq_pkg::SLOT_REL_W:
            begin
                ev.ev_type  = iepq_pkg::TYPE_REL;
                ev.ev_code  = iepq_pkg::AXIS_WHEEL;
                ev.ev_value = rec.dz;
            end
            iepq_pkg::SLOT_KEY:
            begin
                ev.ev_type  = iepq_pkg::TYPE_KEY;
                ev.ev_code  = rec.key_code;
                ev.ev_value = 16'(rec.key_down);
            end
            default:
            begin
                ev = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/input_event_packetizer_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                          | Transfer
// ----------+--------------------------------------------------+-------------------------
// command   | start, busy, command, key_code, key_down,        | start && !busy
//           | button_mask, delta_x, delta_y, delta_wheel       |
// result    | done, status, event_type, event_code,            | done (one cycle)
//           | event_value, key_pressed, queued_count           |
// config    | cfg_we, cfg_wdata (device_kind)                  | cfg_we
//
// One command at a time. A push walks the event slots in order, one ring write per enabled
// slot, then the key map row read-modify-write if the map is updated. A refused or ignored
// push, flush or out-of-map query goes to S_RESP; a read passes S_RING_RD, a query S_QUERY.
// Reset clears pointers, held buttons, key map row valid bits and device_kind;
// no clearing pass. The result receiver cannot stall; results are never held back.

module input_event_packetizer_queue_unit #(
    parameter int QUEUE_DEPTH = iepq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_LIMIT   = iepq_pkg::KEY_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  command,
    input  wire logic [9:0]  key_code,
    input  wire logic        key_down,
    input  wire logic [2:0]  button_mask,
    input  wire logic [15:0] delta_x,
    input  wire logic [15:0] delta_y,
    input  wire logic [15:0] delta_wheel,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    output      logic        done,
    output      logic [1:0]  status,
    output      logic [4:0]  event_type,
    output      logic [9:0]  event_code,
    output      logic [15:0] event_value,
    output      logic        key_pressed,
    output      logic [8:0]  queued_count
);

    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAP_SIZE = KEY_LIMIT + 1;
    localparam int KROWS    = (MAP_SIZE + iepq_pkg::KMAP_ROW_W - 1) / iepq_pkg::KMAP_ROW_W;
    localparam int KROW_W   = $clog2(KROWS);
    localparam int EV_W     = $bits(iepq_pkg::event_t);

    localparam logic [10:0]      MAP_SIZE_L = 11'(MAP_SIZE);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X    = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [KROW_W-1:0] BTN_ROW   = KROW_W'(iepq_pkg::BTN_BASE[9:4]);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WRITE,
        S_KMAP_RD,
        S_KMAP_WR,
        S_RING_RD,
        S_QUERY,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    iepq_pkg::cmd_t          cmd_reg, cmd_next;
    iepq_pkg::record_t       rec_reg, rec_next;
    logic [2:0]              slot_reg, slot_next;
    logic [IDX_W-1:0]        widx_reg, widx_next;
    logic                    wlap_reg, wlap_next;
    logic [IDX_W-1:0]        ridx_reg, ridx_next;
    logic                    rlap_reg, rlap_next;
    logic [2:0]              held_reg, held_next;
    logic [KROWS-1:0]        kvalid_reg, kvalid_next;
    logic                    kind_reg, kind_next;
    logic                    done_reg, done_next;
    iepq_pkg::status_t       status_reg, status_next;
    iepq_pkg::event_t        evout_reg, evout_next;
    logic                    pressed_reg, pressed_next;
    logic [8:0]              qcount_reg, qcount_next;

    iepq_pkg::gen_t          gen;
    iepq_pkg::event_t        slot_ev;
    logic [CNT_W-1:0]        q_cnt;
    logic                    full;
    logic                    ring_we;
    logic                    ring_re;
    logic [EV_W-1:0]         ring_rdata;
    logic                    kmap_we;
    logic                    kmap_re;
    logic [KROW_W-1:0]       kmap_raddr;
    logic [iepq_pkg::KMAP_ROW_W-1:0] kmap_wdata;
    logic [iepq_pkg::KMAP_ROW_W-1:0] kmap_rdata;
    logic [KROW_W-1:0]       key_row;
    logic [KROW_W-1:0]       upd_row;

    iepq_evgen #(
        .KEY_LIMIT(KEY_LIMIT)
    ) u_evgen (
        .rec (rec_reg),
        .held(held_reg),
        .slot(slot_reg),
        .gen (gen),
        .ev  (slot_ev)
    );

    iepq_ram #(
        .WIDTH(EV_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(widx_reg),
        .wdata(slot_ev),
        .re   (ring_re),
        .raddr(ridx_reg),
        .rdata(ring_rdata)
    );

    iepq_ram #(
        .WIDTH(iepq_pkg::KMAP_ROW_W),
        .DEPTH(KROWS)
    ) u_kmap (
        .clk  (clk),
        .we   (kmap_we),
        .waddr(upd_row),
        .wdata(kmap_wdata),
        .re   (kmap_re),
        .raddr(kmap_raddr),
        .rdata(kmap_rdata)
    );

    assign key_row = rec_reg.key_code[iepq_pkg::KMAP_ROW_SH +: KROW_W];
    assign upd_row = rec_reg.kind ? BTN_ROW : key_row;

    always_comb
    begin
        if (wlap_reg == rlap_reg)
        begin
            q_cnt = CNT_W'(widx_reg) - CNT_W'(ridx_reg);
        end
        else
        begin
            q_cnt = CNT_W'(widx_reg) + DEPTH_C - CNT_W'(ridx_reg);
        end
    end

    assign full = ((CNT_W + 1)'(q_cnt) + (CNT_W + 1)'(gen.count)) > DEPTH_X;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        rec_next     = rec_reg;
        slot_next    = slot_reg;
        widx_next    = widx_reg;
        wlap_next    = wlap_reg;
        ridx_next    = ridx_reg;
        rlap_next    = rlap_reg;
        held_next    = held_reg;
        kvalid_next  = kvalid_reg;
        kind_next    = cfg_we ? cfg_wdata : kind_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        evout_next   = evout_reg;
        pressed_next = pressed_reg;
        qcount_next  = qcount_reg;
        ring_we      = 1'b0;
        ring_re      = 1'b0;
        kmap_we      = 1'b0;
        kmap_re      = 1'b0;
        kmap_raddr   = upd_row;
        kmap_wdata   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next          = iepq_pkg::cmd_t'(command);
                    rec_next.kind     = kind_reg;
                    rec_next.key_code = key_code;
                    rec_next.key_down = key_down;
                    rec_next.buttons  = button_mask;
                    rec_next.dx       = delta_x;
                    rec_next.dy       = delta_y;
                    rec_next.dz       = delta_wheel;
                    state_next        = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                status_next  = iepq_pkg::ST_OK;
                evout_next   = '0;
                pressed_next = 1'b0;
                state_next   = S_RESP;
                case (cmd_reg)
                    iepq_pkg::CMD_PUSH:
                    begin
                        if (!gen.ignore)
                        begin
                            if (full)
                            begin
                                status_next = iepq_pkg::ST_FULL;
                            end
                            else
                            begin
                                slot_next  = '0;
                                state_next = S_WRITE;
                            end
                        end
                    end
                    iepq_pkg::CMD_READ:
                    begin
                        if (q_cnt == '0)
                        begin
                            status_next = iepq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ring_re    = 1'b1;
                            state_next = S_RING_RD;
                        end
                    end
                    iepq_pkg::CMD_FLUSH:
                    begin
                        ridx_next = widx_reg;
                        rlap_next = wlap_reg;
                        held_next = '0;
                    end
                    iepq_pkg::CMD_QUERY:
                    begin
                        if ({1'b0, rec_reg.key_code} < MAP_SIZE_L)
                        begin
                            kmap_re    = 1'b1;
                            kmap_raddr = key_row;
                            state_next = S_QUERY;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_WRITE:
            begin
                if (gen.slot_en[slot_reg])
                begin
                    ring_we = 1'b1;
                    if (widx_reg == IDX_LAST)
                    begin
                        widx_next = '0;
                        wlap_next = !wlap_reg;
                    end
                    else
                    begin
                        widx_next = widx_reg + 1'b1;
                    end
                end
                slot_next = slot_reg + 1'b1;
                if (slot_reg == iepq_pkg::SLOT_SYN)
                begin
                    if (rec_reg.kind)
                    begin
                        held_next = rec_reg.buttons;
                    end
                    state_next = gen.kmap_upd ? S_KMAP_RD : S_RESP;
                end
            end
            S_KMAP_RD:
            begin
                kmap_re    = 1'b1;
                state_next = S_KMAP_WR;
            end
            S_KMAP_WR:
            begin
                kmap_wdata = kvalid_reg[upd_row] ? kmap_rdata : '0;
                if (rec_reg.kind)
                begin
                    for (int b = 0; b < 3; b++)
                    begin
                        if (KEY_LIMIT >= int'(iepq_pkg::BTN_BASE) + b)
                        begin
                            kmap_wdata[b] = rec_reg.buttons[b];
                        end
                    end
                end
                else
                begin
                    kmap_wdata[rec_reg.key_code[iepq_pkg::KMAP_ROW_SH-1:0]] = rec_reg.key_down;
                end
                kmap_we              = 1'b1;
                kvalid_next[upd_row] = 1'b1;
                state_next           = S_RESP;
            end
            S_RING_RD:
            begin
                evout_next = iepq_pkg::event_t'(ring_rdata);
                if (ridx_reg == IDX_LAST)
                begin
                    ridx_next = '0;
                    rlap_next = !rlap_reg;
                end
                else
                begin
                    ridx_next = ridx_reg + 1'b1;
                end
                state_next = S_RESP;
            end
            S_QUERY:
            begin
                pressed_next = kvalid_reg[key_row]
                    & kmap_rdata[rec_reg.key_code[iepq_pkg::KMAP_ROW_SH-1:0]];
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                done_next   = 1'b1;
                qcount_next = 9'(q_cnt);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= iepq_pkg::CMD_PUSH;
            rec_reg     <= '0;
            slot_reg    <= '0;
            widx_reg    <= '0;
            wlap_reg    <= 1'b0;
            ridx_reg    <= '0;
            rlap_reg    <= 1'b0;
            held_reg    <= '0;
            kvalid_reg  <= '0;
            kind_reg    <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= iepq_pkg::ST_OK;
            evout_reg   <= '0;
            pressed_reg <= 1'b0;
            qcount_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            rec_reg     <= rec_next;
            slot_reg    <= slot_next;
            widx_reg    <= widx_next;
            wlap_reg    <= wlap_next;
            ridx_reg    <= ridx_next;
            rlap_reg    <= rlap_next;
            held_reg    <= held_next;
            kvalid_reg  <= kvalid_next;
            kind_reg    <= kind_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            evout_reg   <= evout_next;
            pressed_reg <= pressed_next;
            qcount_reg  <= qcount_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign event_type   = evout_reg.ev_type;
    assign event_code   = evout_reg.ev_code;
    assign event_value  = evout_reg.ev_value;
    assign key_pressed  = pressed_reg;
    assign queued_count = qcount_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not followed by busy");

    a_ring_room: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (q_cnt < DEPTH_C))
        else $error("ring write with queue full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == iepq_pkg::ST_EMPTY) |-> (queued_count == 9'd0))
        else $error("empty status with events queued");
`endif

endmodule

`default_nettype wire
